// ===== hw/rtl/wif_pkg.sv =====
// ----------------------------------------------------------------------------
// wif_pkg
// shared constants, types and codes of the wake induction factor pipeline
// ----------------------------------------------------------------------------
package wif_pkg;

	// fixed point format of loads and induction factors
	localparam int FRAC_BITS = 16;

	// scaled quadratic coefficients carry this many fraction bits
	localparam int COEF_FRAC = 27 + FRAC_BITS;
	localparam int G_SHIFT   = 19;
	localparam int T_SHIFT   = 80 - COEF_FRAC;
	localparam int XB_SHIFT  = COEF_FRAC - 14;
	localparam int XC_SHIFT  = COEF_FRAC - 32;

	// 1e-8 in q0.48
	localparam logic [21:0] EPS48 = 22'd2814750;

	// wake transition register reset value (0.4 in q0.16)
	localparam logic [15:0] WT_RESET = 16'd26214;

	// divider operand width and quotient steps
	localparam int OP_W      = 34;
	localparam int MAG_W     = OP_W - 1;
	localparam int DIV_STEPS = MAG_W + FRAC_BITS;

	// one root bit per stage for a 64 bit radicand
	localparam int SQ_STEPS = 32;

	// accept edge to result edge
	localparam int LATENCY = 10 + SQ_STEPS + 4 + DIV_STEPS;

	localparam logic signed [OP_W-1:0] ONE_OP = OP_W'(64'sd1 <<< FRAC_BITS);

	localparam int LANE_AX = 0;
	localparam int LANE_TG = 1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SAT     = 2'd1,
		ST_NEGDISC = 2'd2
	} status_t;

	// per item side information that travels beside the coefficient math
	typedef struct packed {
		logic signed [31:0] k;
		logic signed [31:0] kr;
		logic               phi_pos;
		logic               brake;
		logic               mom;
		logic               negdisc;
		logic signed [30:0] a;
		logic signed [30:0] b;
		logic signed [30:0] c;
	} side_t;

	// control that travels with a divider request
	typedef struct packed {
		logic valid;
		logic negdisc;
	} div_ctl_t;

endpackage

// ===== hw/rtl/wif_coef.sv =====
// ----------------------------------------------------------------------------
// wif_coef
// ten stage front end: region test, scaled quadratic coefficients,
// epsilon clamp, block scaling and discriminant
// ----------------------------------------------------------------------------
module wif_coef (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [15:0]           x,
	input  logic signed [31:0]    flow_angle,
	input  logic signed [31:0]    axial_load,
	input  logic [16:0]           loss_factor,
	input  logic signed [31:0]    tangential_load,
	output logic                  out_valid,
	output logic [63:0]           radicand,
	output wif_pkg::side_t        side
);

	localparam logic [21:0] EPS_EXT = wif_pkg::EPS48;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [30:0] apply_sign(input logic [63:0] m, input logic neg);
		logic signed [30:0] p;
		p = signed'({1'b0, m[29:0]});
		return neg ? 31'(-p) : p;
	endfunction

	logic [9:0] valid_q;

	wif_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	wif_pkg::side_t side_s6, side_s7, side_s8, side_s9, side_s10;

	// next side values of the stages that update some fields
	wif_pkg::side_t side2_w, side8_w, side10_w;

	logic [16:0]        d_w;
	logic signed [49:0] xf_w;
	logic [16:0]        f_s1;
	logic signed [49:0] kd_s1;
	logic [32:0]        dd_s1;
	logic [31:0]        xx_s1, xx_s2, xx_s3;
	logic [49:0]        g_full_s2;
	logic [63:0]        t_full_s2;
	logic [63:0]        t_s3, t_s4;
	logic signed [63:0] ga_s3, gb_s3, gc_s3;
	logic signed [63:0] a_s4, b_s4, c_s4;
	logic signed [63:0] a_s5, b_s5, c_s5;
	logic [63:0]        ma_s6, mb_s6, mc_s6, orm_s6;
	logic               sa_s6, sb_s6, sc_s6;
	logic [63:0]        ma_s7, mb_s7, mc_s7;
	logic               sa_s7, sb_s7, sc_s7;
	logic [5:0]         r_s7;
	logic signed [61:0] bb_s9, ac_s9;
	logic [63:0]        radicand_s10;

	// stage 3 products
	logic signed [31:0]            gs_w;
	logic signed [wif_pkg::OP_W-1:0] k_op_w, kp1_w, k2p1_w;
	logic signed [65:0]            pa_w, pb_w, pc_w;

	// stage 5 clamp
	logic [63:0]        ma4_w;
	logic signed [63:0] acl_w;

	// stage 7 shift count
	logic [5:0] msb_w;
	logic [5:0] r_w;

	// stage 10 discriminant
	logic signed [63:0] disc_w;

	assign d_w  = 17'h10000 - {1'b0, x};
	assign xf_w = signed'({1'b0, 49'(x) << wif_pkg::FRAC_BITS});

	always_comb begin
		gs_w   = signed'({1'b0, 31'(g_full_s2 >> wif_pkg::G_SHIFT)});
		k_op_w = wif_pkg::OP_W'(side_s2.k);
		kp1_w  = k_op_w + wif_pkg::ONE_OP;
		k2p1_w = (k_op_w <<< 1) + wif_pkg::ONE_OP;
		pa_w   = gs_w * kp1_w;
		pb_w   = gs_w * k2p1_w;
		pc_w   = gs_w * k_op_w;
	end

	always_comb begin
		ma4_w = mag64(a_s4);
		acl_w = (ma4_w < t_s4) ? signed'(t_s4) : a_s4;
	end

	always_comb begin
		msb_w = '0;
		for (int i = 0; i < 64; i++) begin
			if (orm_s6[i]) msb_w = 6'(i);
		end
		r_w = (msb_w >= 6'd30) ? msb_w - 6'd29 : 6'd0;
	end

	assign disc_w = 64'(bb_s9) - (64'(ac_s9) <<< 2);

	always_comb begin
		side2_w      = side_s1;
		side2_w.mom  = kd_s1 <= xf_w;
		side8_w      = side_s7;
		side8_w.a    = apply_sign(ma_s7 >> r_s7, sa_s7);
		side8_w.b    = apply_sign(mb_s7 >> r_s7, sb_s7);
		side8_w.c    = apply_sign(mc_s7 >> r_s7, sc_s7);
		side10_w         = side_s9;
		side10_w.negdisc = disc_w[63];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[8:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: capture and first products
		side_s1.k       <= axial_load;
		side_s1.kr      <= tangential_load;
		side_s1.phi_pos <= flow_angle > 32'sd0;
		side_s1.brake   <= wif_pkg::OP_W'(axial_load) > wif_pkg::ONE_OP;
		side_s1.mom     <= 1'b0;
		side_s1.negdisc <= 1'b0;
		side_s1.a       <= '0;
		side_s1.b       <= '0;
		side_s1.c       <= '0;
		f_s1            <= loss_factor;
		kd_s1           <= axial_load * signed'({1'b0, d_w});
		dd_s1           <= d_w * d_w;
		xx_s1           <= x * x;

		// stage 2: momentum test, loss and epsilon products
		side_s2   <= side2_w;
		g_full_s2 <= f_s1 * dd_s1;
		t_full_s2 <= EPS_EXT * dd_s1;
		xx_s2     <= xx_s1;

		// stage 3: g times the load terms
		side_s3 <= side_s2;
		t_s3    <= t_full_s2 >> wif_pkg::T_SHIFT;
		ga_s3   <= pa_w[63:0];
		gb_s3   <= pb_w[63:0];
		gc_s3   <= pc_w[63:0];
		xx_s3   <= xx_s2;

		// stage 4: coefficients
		side_s4 <= side_s3;
		t_s4    <= t_s3;
		a_s4    <= (64'sd2 <<< wif_pkg::COEF_FRAC) - ga_s3;
		b_s4    <= gb_s3 - signed'(64'(x) << wif_pkg::XB_SHIFT);
		c_s4    <= signed'(64'({xx_s3, 1'b0}) << wif_pkg::XC_SHIFT) - gc_s3;

		// stage 5: leading coefficient clamp
		side_s5 <= side_s4;
		a_s5    <= (acl_w == 64'sd0) ? 64'sd1 : acl_w;
		b_s5    <= b_s4;
		c_s5    <= c_s4;

		// stage 6: magnitudes
		side_s6 <= side_s5;
		ma_s6   <= mag64(a_s5);
		mb_s6   <= mag64(b_s5);
		mc_s6   <= mag64(c_s5);
		orm_s6  <= mag64(a_s5) | mag64(b_s5) | mag64(c_s5);
		sa_s6   <= a_s5[63];
		sb_s6   <= b_s5[63];
		sc_s6   <= c_s5[63];

		// stage 7: common shift
		side_s7 <= side_s6;
		ma_s7   <= ma_s6;
		mb_s7   <= mb_s6;
		mc_s7   <= mc_s6;
		sa_s7   <= sa_s6;
		sb_s7   <= sb_s6;
		sc_s7   <= sc_s6;
		r_s7    <= r_w;

		// stage 8: scaled coefficients
		side_s8 <= side8_w;

		// stage 9: discriminant products
		side_s9 <= side_s8;
		bb_s9   <= side_s8.b * side_s8.b;
		ac_s9   <= side_s8.a * side_s8.c;

		// stage 10: discriminant
		side_s10     <= side10_w;
		radicand_s10 <= disc_w[63] ? 64'd0 : 64'(disc_w);
	end

	assign out_valid = valid_q[9];
	assign radicand  = radicand_s10;
	assign side      = side_s10;

endmodule

// ===== hw/rtl/wif_sqrt.sv =====
// ----------------------------------------------------------------------------
// wif_sqrt
// integer square root, one root bit per pipeline stage
// ----------------------------------------------------------------------------
module wif_sqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [63:0]    radicand,
	input  wif_pkg::side_t side_in,
	output logic           out_valid,
	output logic [31:0]    root,
	output wif_pkg::side_t side_out
);

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sq_st_t;

	// bring down two radicand bits, try (root << 2) | 1
	function automatic sq_st_t step(input sq_st_t s);
		sq_st_t      r;
		logic [34:0] rem2;
		logic [34:0] trial;
		logic        ge;
		rem2   = {s.rem[32:0], s.rad[63:62]};
		trial  = {1'b0, s.root, 2'b01};
		ge     = rem2 >= trial;
		r.rem  = ge ? rem2 - trial : rem2;
		r.root = {s.root[30:0], ge};
		r.rad  = {s.rad[61:0], 2'b00};
		return r;
	endfunction

	sq_st_t                 pipe_s [wif_pkg::SQ_STEPS];
	wif_pkg::side_t         side_s [wif_pkg::SQ_STEPS];
	logic [wif_pkg::SQ_STEPS-1:0] valid_q;
	sq_st_t                 first_w;

	assign first_w = '{rem: '0, root: '0, rad: radicand};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[wif_pkg::SQ_STEPS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		pipe_s[0] <= step(first_w);
		side_s[0] <= side_in;
		for (int i = 1; i < wif_pkg::SQ_STEPS; i++) begin
			pipe_s[i] <= step(pipe_s[i-1]);
			side_s[i] <= side_s[i-1];
		end
	end

	assign out_valid = valid_q[wif_pkg::SQ_STEPS-1];
	assign root      = pipe_s[wif_pkg::SQ_STEPS-1].root;
	assign side_out  = side_s[wif_pkg::SQ_STEPS-1];

endmodule

// ===== hw/rtl/wif_div.sv =====
// ----------------------------------------------------------------------------
// wif_div
// two lane pipelined fixed point divider, one quotient bit per stage,
// saturating to 32 bits
// ----------------------------------------------------------------------------
module wif_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wif_pkg::div_ctl_t                 ctl_in,
	input  logic signed [wif_pkg::OP_W-1:0]   num [2],
	input  logic signed [wif_pkg::OP_W-1:0]   den [2],
	output wif_pkg::div_ctl_t                 ctl_out,
	output logic signed [31:0]                quot [2],
	output logic [1:0]                        sat
);

	typedef struct packed {
		logic [wif_pkg::MAG_W:0]       rem;
		logic [wif_pkg::DIV_STEPS-1:0] dv;
		logic [wif_pkg::DIV_STEPS-1:0] q;
		logic [wif_pkg::MAG_W-1:0]     ud;
		logic                          neg;
		logic                          dz;
		logic                          npos;
		logic                          nneg;
	} div_st_t;

	function automatic div_st_t prep(input logic signed [wif_pkg::OP_W-1:0] n,
			input logic signed [wif_pkg::OP_W-1:0] d);
		div_st_t                 s;
		logic [wif_pkg::OP_W-1:0] un;
		logic [wif_pkg::OP_W-1:0] ud;
		un     = n[wif_pkg::OP_W-1] ? wif_pkg::OP_W'(-n) : wif_pkg::OP_W'(n);
		ud     = d[wif_pkg::OP_W-1] ? wif_pkg::OP_W'(-d) : wif_pkg::OP_W'(d);
		s.rem  = '0;
		s.dv   = {un[wif_pkg::MAG_W-1:0], {wif_pkg::FRAC_BITS{1'b0}}};
		s.q    = '0;
		s.ud   = ud[wif_pkg::MAG_W-1:0];
		s.neg  = n[wif_pkg::OP_W-1] ^ d[wif_pkg::OP_W-1];
		s.dz   = d == '0;
		s.npos = !n[wif_pkg::OP_W-1] && n != '0;
		s.nneg = n[wif_pkg::OP_W-1];
		return s;
	endfunction

	function automatic div_st_t step(input div_st_t s);
		div_st_t                 r;
		logic [wif_pkg::MAG_W:0] rem2;
		logic                    ge;
		r    = s;
		rem2 = {s.rem[wif_pkg::MAG_W-1:0], s.dv[wif_pkg::DIV_STEPS-1]};
		ge   = rem2 >= {1'b0, s.ud};
		r.rem = ge ? rem2 - {1'b0, s.ud} : rem2;
		r.q   = {s.q[wif_pkg::DIV_STEPS-2:0], ge};
		r.dv  = {s.dv[wif_pkg::DIV_STEPS-2:0], 1'b0};
		return r;
	endfunction

	// {saturated, quotient}
	function automatic logic [32:0] finish(input div_st_t s);
		logic [31:0] q;
		logic        st;
		logic        over;
		q    = s.q[31:0];
		st   = 1'b0;
		over = (s.q[wif_pkg::DIV_STEPS-1:32] != '0) || (s.q[31] && s.q[30:0] != '0);
		if (s.dz) begin
			st = 1'b1;
			if (s.npos) q = 32'h7FFF_FFFF;
			else if (s.nneg) q = 32'h8000_0000;
			else q = '0;
		end else if (!s.neg) begin
			if (s.q[wif_pkg::DIV_STEPS-1:31] != '0) begin
				st = 1'b1;
				q  = 32'h7FFF_FFFF;
			end
		end else if (over) begin
			st = 1'b1;
			q  = 32'h8000_0000;
		end else begin
			q = ~s.q[31:0] + 32'd1;
		end
		return {st, q};
	endfunction

	div_st_t                         pipe_s [2][wif_pkg::DIV_STEPS+1];
	logic [wif_pkg::DIV_STEPS:0]     tag_s;
	logic                            tag_fin_s;
	logic [wif_pkg::DIV_STEPS+1:0]   valid_q;
	logic signed [31:0]              quot_s [2];
	logic [1:0]                      sat_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[wif_pkg::DIV_STEPS:0], ctl_in.valid};
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			pipe_s[l][0] <= prep(num[l], den[l]);
			for (int i = 1; i <= wif_pkg::DIV_STEPS; i++) begin
				pipe_s[l][i] <= step(pipe_s[l][i-1]);
			end
			{sat_s[l], quot_s[l]} <= finish(pipe_s[l][wif_pkg::DIV_STEPS]);
		end
		tag_s     <= {tag_s[wif_pkg::DIV_STEPS-1:0], ctl_in.negdisc};
		tag_fin_s <= tag_s[wif_pkg::DIV_STEPS];
	end

	assign ctl_out = '{valid: valid_q[wif_pkg::DIV_STEPS+1], negdisc: tag_fin_s};
	assign quot    = quot_s;
	assign sat     = sat_s;

endmodule

// ===== hw/rtl/wake_induction_factors.sv =====
// ----------------------------------------------------------------------------
// wake_induction_factors
// throughput: one request per cycle; busy is always low, results never wait
// the depth comes from the 32 stage root and the one bit per stage divider
// reset: arst_n clears all valid bits and loads the transition point with 0.4
// ----------------------------------------------------------------------------
module wake_induction_factors (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] flow_angle,
	input  logic signed [31:0] axial_load,
	input  logic [16:0]        loss_factor,
	input  logic signed [31:0] tangential_load,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	output logic               done,
	output logic signed [31:0] axial_induction,
	output logic signed [31:0] tangential_induction,
	output logic [1:0]         status
);

	// transition point x, q0.16
	logic [15:0] transition_pt_q;

	// front end outputs
	logic           coef_valid;
	logic [63:0]    coef_rad;
	wif_pkg::side_t coef_side;

	// root outputs
	logic           sq_valid;
	logic [31:0]    sq_root;
	wif_pkg::side_t sq_side;

	// root selection and divider requests
	logic signed [wif_pkg::OP_W-1:0] b_op, s_op, bs_w, emp_n, emp_d;
	logic signed [wif_pkg::OP_W-1:0] k_op, kr_op, ax_n, ax_d;
	logic signed [wif_pkg::OP_W-1:0] num_s11 [2];
	logic signed [wif_pkg::OP_W-1:0] den_s11 [2];
	wif_pkg::div_ctl_t               ctl_s11;
	logic                            valid_s11;
	logic                            negdisc_s11;

	// divider outputs
	wif_pkg::div_ctl_t  div_ctl;
	logic signed [31:0] div_q [2];
	logic [1:0]         div_sat;

	// result registers
	logic               done_q;
	logic signed [31:0] axial_q, tang_q;
	wif_pkg::status_t   status_q;

	// the pipeline never stalls, so a request is always taken
	assign busy = 1'b0;

	// config register: user writes only while no request is in flight; unchecked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transition_pt_q <= wif_pkg::WT_RESET;
		end else if (cfg_wr_en) begin
			transition_pt_q <= cfg_wr_data;
		end
	end

	// region test, coefficients, clamp, block scaling, discriminant
	wif_coef u_coef (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (start && !busy),
		.x               (transition_pt_q),
		.flow_angle      (flow_angle),
		.axial_load      (axial_load),
		.loss_factor     (loss_factor),
		.tangential_load (tangential_load),
		.out_valid       (coef_valid),
		.radicand        (coef_rad),
		.side            (coef_side)
	);

	// floor square root of the discriminant
	wif_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (coef_valid),
		.radicand  (coef_rad),
		.side_in   (coef_side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	// pick the numerically safe root form and the axial region
	always_comb begin
		b_op  = wif_pkg::OP_W'(sq_side.b);
		s_op  = signed'(wif_pkg::OP_W'(sq_root));
		bs_w  = b_op + s_op;
		k_op  = wif_pkg::OP_W'(sq_side.k);
		kr_op = wif_pkg::OP_W'(sq_side.kr);

		// -2c/(b+s) avoids cancellation when b is not negative
		if (!sq_side.b[30] && bs_w != '0) begin
			emp_n = -(wif_pkg::OP_W'(sq_side.c) <<< 1);
			emp_d = bs_w;
		end else begin
			emp_n = s_op - b_op;
			emp_d = wif_pkg::OP_W'(sq_side.a) <<< 1;
		end

		// 0/1 stands in for a plain zero: it divides to 0 with no saturation
		priority if (!sq_side.phi_pos) begin
			if (sq_side.brake) begin
				ax_n = k_op;
				ax_d = k_op - wif_pkg::ONE_OP;
			end else begin
				ax_n = '0;
				ax_d = wif_pkg::OP_W'(1);
			end
		end else if (sq_side.mom) begin
			ax_n = k_op;
			ax_d = k_op + wif_pkg::ONE_OP;
		end else if (sq_side.negdisc) begin
			ax_n = '0;
			ax_d = wif_pkg::OP_W'(1);
		end else begin
			ax_n = emp_n;
			ax_d = emp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else begin
			valid_s11 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		num_s11[wif_pkg::LANE_AX] <= ax_n;
		den_s11[wif_pkg::LANE_AX] <= ax_d;
		num_s11[wif_pkg::LANE_TG] <= kr_op;
		den_s11[wif_pkg::LANE_TG] <= wif_pkg::ONE_OP - kr_op;
		negdisc_s11               <= sq_side.negdisc && sq_side.phi_pos && !sq_side.mom;
	end

	assign ctl_s11 = '{valid: valid_s11, negdisc: negdisc_s11};

	// axial and tangential divisions side by side
	wif_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s11),
		.num     (num_s11),
		.den     (den_s11),
		.ctl_out (div_ctl),
		.quot    (div_q),
		.sat     (div_sat)
	);

	// result strobe lasts one cycle per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_ctl.valid;
		end
	end

	// negative discriminant wins over saturation
	always_ff @(posedge clk) begin
		axial_q <= div_q[wif_pkg::LANE_AX];
		tang_q  <= div_q[wif_pkg::LANE_TG];
		if (div_ctl.negdisc) status_q <= wif_pkg::ST_NEGDISC;
		else if (div_sat != 2'b00) status_q <= wif_pkg::ST_SAT;
		else status_q <= wif_pkg::ST_OK;
	end

	assign done                 = done_q;
	assign axial_induction      = axial_q;
	assign tangential_induction = tang_q;
	assign status               = status_q;

	// every request comes out after the fixed pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(wif_pkg::LATENCY) done)
		else $error("request did not complete after pipeline depth");

	// a negative discriminant forces a zero axial factor
	a_negdisc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == wif_pkg::ST_NEGDISC) |-> (axial_induction == 32'sd0))
		else $error("negative discriminant with nonzero axial factor");

endmodule
